// ===== rtl/i2c_pointer_register_slave_top_macros.svh =====
// Assertion macros used by the checker file of the register slave.
`ifndef I2C_POINTER_REGISTER_SLAVE_TOP_MACROS_SVH
`define I2C_POINTER_REGISTER_SLAVE_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define IPR_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define IPR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/ipr_pkg.sv =====
package ipr_pkg;

  // Default pointer width; the register file holds 2**IPR_POINTER_BITS bytes.
  localparam int IPR_POINTER_BITS = 7;

  // Bus event codes.
  typedef enum logic [2:0] {
    OP_ADDR_WRITE  = 3'd0,
    OP_ADDR_READ   = 3'd1,
    OP_TX_EMPTY    = 3'd2,
    OP_RX_BYTE     = 3'd3,
    OP_NACK        = 3'd4,
    OP_RX_FINISHED = 3'd5,
    OP_STOP        = 3'd6
  } ipr_op_t;

  // Access request from the controller to the register file.
  typedef struct packed {
    logic       wr_en;
    logic       rd_en;
    logic [7:0] wdata;
  } ipr_mem_req_t;

endpackage

// ===== rtl/ipr_regfile.sv =====
module ipr_regfile #(
  parameter int POINTER_BITS = ipr_pkg::IPR_POINTER_BITS
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  ipr_pkg::ipr_mem_req_t    req,
  input  logic [POINTER_BITS-1:0]  addr,
  output logic [7:0]               rdata,
  output logic                     init_busy
);
  import ipr_pkg::*;

  localparam int DEPTH = 1 << POINTER_BITS;

  logic [7:0]              mem [DEPTH];
  logic [7:0]              rdata_r;
  logic                    busy_r;
  logic                    busy_nxt;
  logic [POINTER_BITS-1:0] cnt_r;
  logic [POINTER_BITS-1:0] cnt_nxt;
  logic [POINTER_BITS+7:0] cnt_ext;
  logic                    wr_en;
  logic [POINTER_BITS-1:0] wr_addr;
  logic [7:0]              wr_data;

  // The init sweep owns the write port until every entry holds its index.
  always_comb begin
    cnt_ext  = {8'd0, cnt_r};
    wr_en    = busy_r | req.wr_en;
    wr_addr  = busy_r ? cnt_r : addr;
    wr_data  = busy_r ? cnt_ext[7:0] : req.wdata;
    busy_nxt = busy_r & ~(&cnt_r);
    cnt_nxt  = busy_r ? cnt_r + 1'b1 : cnt_r;
  end

  // Sweep counter and busy flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Single-port style storage with a registered read.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (req.rd_en) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata     = rdata_r;
  assign init_busy = busy_r;

endmodule

// ===== rtl/ipr_ctrl.sv =====
module ipr_ctrl #(
  parameter int POINTER_BITS = ipr_pkg::IPR_POINTER_BITS
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [2:0]               in_operation,
  input  logic [7:0]               in_rx_data,
  output logic                     out_valid,
  input  logic                     out_stall,
  input  logic                     init_busy,
  output ipr_pkg::ipr_mem_req_t    mem_req,
  output logic [POINTER_BITS-1:0]  mem_addr
);
  import ipr_pkg::*;

  logic [POINTER_BITS-1:0] ptr_r;
  logic [POINTER_BITS-1:0] ptr_nxt;
  logic                    pend_r;
  logic                    pend_nxt;
  logic                    out_valid_r;
  logic                    out_valid_nxt;
  logic [POINTER_BITS+7:0] rx_ext;
  logic                    is_read;
  logic                    accept;
  ipr_op_t                 op;

  // A read request waits while an earlier result is still held; every event waits during init.
  always_comb begin
    op       = ipr_op_t'(in_operation);
    is_read  = (op == OP_ADDR_READ) || (op == OP_TX_EMPTY);
    in_stall = init_busy | (out_valid_r & out_stall & is_read);
    accept   = in_valid & ~in_stall;
    rx_ext   = {{POINTER_BITS{1'b0}}, in_rx_data};
  end

  // Pointer, load flag and memory request for the accepted event.
  always_comb begin
    ptr_nxt       = ptr_r;
    pend_nxt      = pend_r;
    mem_req.wr_en = 1'b0;
    mem_req.rd_en = 1'b0;
    mem_req.wdata = in_rx_data;
    if (accept) begin
      case (op)
        OP_ADDR_WRITE: begin
          pend_nxt = 1'b1;
        end
        OP_ADDR_READ, OP_TX_EMPTY: begin
          mem_req.rd_en = 1'b1;
          ptr_nxt       = ptr_r + 1'b1;
        end
        OP_RX_BYTE: begin
          if (pend_r) begin
            pend_nxt = 1'b0;
            ptr_nxt  = rx_ext[POINTER_BITS-1:0];
          end else begin
            mem_req.wr_en = 1'b1;
            ptr_nxt       = ptr_r + 1'b1;
          end
        end
        OP_NACK: begin
          ptr_nxt = ptr_r - 1'b1;
        end
        OP_RX_FINISHED: begin
          ptr_nxt = ptr_r + 2'd2;
        end
        default: begin
          ptr_nxt = ptr_r;
        end
      endcase
    end
  end

  // The read data lands in the register file's output register next cycle.
  always_comb begin
    if (accept && is_read) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      ptr_r       <= ptr_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign mem_addr  = ptr_r;
  assign out_valid = out_valid_r;

endmodule

// ===== rtl/i2c_pointer_register_slave_top.sv =====
// Channel | Direction | Handshake           | Payload
// in_     | input     | in_valid / in_stall | in_operation[2:0], in_rx_data[7:0]
// out_    | output    | out_valid/out_stall | out_tx_data[7:0]
//
// A read result appears in the cycle after its request, out of the
// register file's registered read port. After reset an init sweep writes
// each entry with its own index, one entry a cycle; in_stall stays high
// meanwhile. A read request stalls while the previous result is still
// held by out_stall; all other events are taken every cycle outside the
// init sweep.
module i2c_pointer_register_slave_top #(
  parameter int POINTER_BITS = ipr_pkg::IPR_POINTER_BITS
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [2:0] in_operation,
  input  logic [7:0] in_rx_data,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_tx_data
);
  import ipr_pkg::*;

  ipr_mem_req_t            mem_req;
  logic [POINTER_BITS-1:0] mem_addr;
  logic                    init_busy;

  // Event decode, pointer and result handshake.
  ipr_ctrl #(
    .POINTER_BITS(POINTER_BITS)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_operation(in_operation),
    .in_rx_data  (in_rx_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .init_busy   (init_busy),
    .mem_req     (mem_req),
    .mem_addr    (mem_addr)
  );

  // Byte register file.
  ipr_regfile #(
    .POINTER_BITS(POINTER_BITS)
  ) u_regfile (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (mem_req),
    .addr     (mem_addr),
    .rdata    (out_tx_data),
    .init_busy(init_busy)
  );

endmodule

// ===== rtl/ipr_checker.sv =====
`include "i2c_pointer_register_slave_top_macros.svh"

module ipr_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic [2:0] in_operation,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_tx_data
);
  import ipr_pkg::*;

  logic in_read;
  logic in_take;

  assign in_read = (in_operation == OP_ADDR_READ) || (in_operation == OP_TX_EMPTY);
  assign in_take = in_valid & ~in_stall;

  // A held result keeps its valid.
  `IPR_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid, "result dropped while stalled")

  // A held result keeps its data.
  `IPR_ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && out_stall, $stable(out_tx_data), "result changed while stalled")

  // Every accepted read request yields a result in the next cycle.
  `IPR_ASSERT_NEXT(a_read_result, clk, rst_n, in_take && in_read, out_valid, "read request gave no result")

  // Other requests never create a result.
  `IPR_ASSERT_NEXT(a_no_spurious, clk, rst_n, !(in_take && in_read) && !(out_valid && out_stall), !out_valid, "result without a read request")

endmodule

bind i2c_pointer_register_slave_top ipr_checker u_ipr_checker (.*);
